// ----- rtl/core/radius_node_subsampler_top_macros.svh -----
// Assertion macros shared by the subsampler modules.
// Each macro takes a label, clock, active-low reset, antecedent, consequent
// and a message string.
`ifndef RADIUS_NODE_SUBSAMPLER_TOP_MACROS_SVH
`define RADIUS_NODE_SUBSAMPLER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define RNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define RNS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define RNS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ----- rtl/core/rns_pkg.sv -----
package rns_pkg;

  // Node table geometry.
  localparam int MAX_NODES = 4096;
  localparam int IDX_W     = $clog2(MAX_NODES);
  localparam int CNT_W     = IDX_W + 1;

  // Fixed field widths of the stream words.
  localparam int COORD_W   = 20;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int SQ_W      = 2 * DIFF_W;
  localparam int RAD_W     = 44;
  localparam int OUT_IDX_W = 12;
  localparam int OUT_CNT_W = 13;
  localparam int NODE_W    = 3 * COORD_W;

  localparam logic [RAD_W-1:0] RAD_RESET = 44'd2684355;

  // Opcode carried in the input tuser.
  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_POINT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // latch the input word and restart the scan
    logic issue;   // read the next node and advance the scan address
    logic commit;  // update the table and load the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clear_op;    // latched word is a clear
    logic count_zero;  // table is empty
    logic scan_last;   // scan address points at the last stored node
    logic pipe_busy;   // distance pipeline still holds a node
    logic out_free;    // output register can take a result this cycle
  } sts_t;

endpackage

// ----- rtl/core/rns_ctrl.sv -----
`include "radius_node_subsampler_top_macros.svh"

module rns_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  rns_pkg::sts_t sts,
  output rns_pkg::cmd_t cmd
);
  import rns_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        if (sts.clear_op || sts.count_zero) begin
          state_nxt = ST_COMMIT;
        end else begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts.pipe_busy) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
      end
      ST_COMMIT: begin
        cmd.commit = sts.out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // The decision must see every compare of the scan.
  `RNS_ASSERT_IMP(a_commit_drained, clk, rst_n, cmd.commit, !sts.pipe_busy, "commit with busy pipe")
  // A word is only taken when no result is being committed or scanned.
  `RNS_ASSERT_IMP(a_load_quiet, clk, rst_n, cmd.load, !cmd.issue && !cmd.commit, "load during work")

endmodule

// ----- rtl/core/rns_dpath.sv -----
`include "radius_node_subsampler_top_macros.svh"

module rns_dpath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [rns_pkg::RAD_W-1:0]   cfg_wdata,
  input  logic [63:0]                 in_tdata,
  input  logic                        in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [31:0]                 out_tdata,
  output logic [1:0]                  out_tuser,
  input  rns_pkg::cmd_t               cmd,
  output rns_pkg::sts_t               sts
);
  import rns_pkg::*;

  logic [RAD_W-1:0]   radius_r;
  logic               op_r;
  logic [NODE_W-1:0]  point_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic [IDX_W-1:0]   rd_addr_r;
  logic [CNT_W-1:0]   count_m1;
  logic [NODE_W-1:0]  node_q_r;
  logic               rd_vld_r;
  logic [SQ_W-1:0]    sqx_r;
  logic [SQ_W-1:0]    sqy_r;
  logic [SQ_W-1:0]    sqz_r;
  logic               sq_vld_r;
  logic               hit_r;
  logic               out_tvalid_r;
  logic               acc_r;
  logic               drop_r;
  logic [OUT_IDX_W-1:0] idx_r;
  logic [OUT_CNT_W-1:0] cnt_out_r;

  logic               full;
  logic               acc_nxt;
  logic               drop_nxt;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic signed [DIFF_W-1:0] dz;
  logic signed [SQ_W-1:0]   px2;
  logic signed [SQ_W-1:0]   py2;
  logic signed [SQ_W-1:0]   pz2;
  logic [RAD_W-1:0]   dist_sum;

  logic [NODE_W-1:0]  node_mem [MAX_NODES];

  // Radius register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_RESET;
    end else if (cfg_we) begin
      radius_r <= cfg_wdata;
    end
  end

  // Latched input word; point packed {z, y, x}.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_tuser;
      point_r <= in_tdata[NODE_W-1:0];
    end
  end

  // Scan address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_addr_r <= '0;
    end else if (cmd.load) begin
      rd_addr_r <= '0;
    end else if (cmd.issue) begin
      rd_addr_r <= rd_addr_r + 1'b1;
    end
  end

  assign count_m1 = count_r - 1'b1;

  // Node table: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.commit && acc_nxt) begin
      node_mem[count_r[IDX_W-1:0]] <= point_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      node_q_r <= node_mem[rd_addr_r];
    end
  end

  // Per-axis differences and squares of the node just read.
  always_comb begin
    dx  = DIFF_W'($signed(point_r[COORD_W-1:0]))
        - DIFF_W'($signed(node_q_r[COORD_W-1:0]));
    dy  = DIFF_W'($signed(point_r[2*COORD_W-1:COORD_W]))
        - DIFF_W'($signed(node_q_r[2*COORD_W-1:COORD_W]));
    dz  = DIFF_W'($signed(point_r[3*COORD_W-1:2*COORD_W]))
        - DIFF_W'($signed(node_q_r[3*COORD_W-1:2*COORD_W]));
    px2 = dx * dx;
    py2 = dy * dy;
    pz2 = dz * dz;
  end

  always_ff @(posedge clk) begin
    sqx_r <= $unsigned(px2);
    sqy_r <= $unsigned(py2);
    sqz_r <= $unsigned(pz2);
  end

  // Sum of squares, compared against the radius square.
  assign dist_sum = RAD_W'(sqx_r) + RAD_W'(sqy_r) + RAD_W'(sqz_r);

  // Pipeline valids and the hit flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      sq_vld_r <= 1'b0;
      hit_r    <= 1'b0;
    end else begin
      rd_vld_r <= cmd.issue;
      sq_vld_r <= rd_vld_r;
      if (cmd.load) begin
        hit_r <= 1'b0;
      end else if (sq_vld_r && (dist_sum < radius_r)) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Decision and new node count.
  assign full     = (count_r == CNT_W'(MAX_NODES));
  assign acc_nxt  = (op_r == OP_POINT) && !hit_r && !full;
  assign drop_nxt = (op_r == OP_POINT) && !hit_r && full;

  always_comb begin
    count_nxt = count_r;
    if (op_r == OP_CLEAR) begin
      count_nxt = '0;
    end else if (acc_nxt) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      acc_r     <= acc_nxt;
      drop_r    <= drop_nxt;
      idx_r     <= acc_nxt ? OUT_IDX_W'(count_r) : '0;
      cnt_out_r <= OUT_CNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = {drop_r, acc_r};
  assign out_tdata  = {7'd0, cnt_out_r, idx_r};

  // Status to the controller.
  assign sts.clear_op   = (op_r == OP_CLEAR);
  assign sts.count_zero = (count_r == '0);
  assign sts.scan_last  = (rd_addr_r == count_m1[IDX_W-1:0]);
  assign sts.pipe_busy  = rd_vld_r || sq_vld_r;
  assign sts.out_free   = !out_tvalid_r || out_tready;

  // Table never holds more than its capacity.
  `RNS_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_r <= CNT_W'(MAX_NODES), "count overflow")
  // Only stored nodes are ever read.
  `RNS_ASSERT_IMP(a_read_stored, clk, rst_n, cmd.issue, CNT_W'(rd_addr_r) < count_r, "read past count")
  // An appended node bumps the count by exactly one.
  `RNS_ASSERT_NXT(a_append_step, clk, rst_n, cmd.commit && acc_nxt, count_r == $past(count_r) + 1'b1, "bad append")

endmodule

// ----- rtl/core/radius_node_subsampler_top.sv -----
// Radius node subsampler.
// Input stream: in_tuser is the opcode (clear the node table, or offer a
// point); in_tdata carries the point coordinates. Each input word yields
// exactly one result word on the output stream, in order.
// A candidate point is compared with every stored node, one node per
// cycle through a pipelined squared-distance unit fed by the node memory.
// It is appended if no node lies strictly within the radius, or flagged as
// dropped when the table is full.
// Sequence: a point word is taken in ST_IDLE and passes ST_START, a scan of the
// stored nodes in ST_SCAN, ST_DRAIN and ST_COMMIT; a clear word, or a point on
// an empty table, goes from ST_START straight to ST_COMMIT. No new word is taken
// before the commit, and the scan over the node memory read port dominates.
// Reset empties the table and loads the default radius square; the node
// memory itself is not cleared, since only entries below the count are read.
// The result sits in an output register: a new input word is taken while it
// waits, but the next result is held back until the receiver takes it.
// The user must write the radius register via cfg_we/cfg_wdata only while idle; the block does not enforce it.
module radius_node_subsampler_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [rns_pkg::RAD_W-1:0] cfg_wdata,   // radius_square
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [63:0]               in_tdata,    // point_x, point_y, point_z, zero pad
  input  logic                      in_tuser,    // opcode
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [31:0]               out_tdata,   // new_index, stored_count, zero pad
  output logic [1:0]                out_tuser    // accepted, dropped_full
);
  import rns_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  rns_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Node table, distance pipeline and output register.
  rns_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

// ----- dv/radius_node_subsampler_top_test.sv -----
`timescale 1ns / 1ps

module radius_node_subsampler_top_test;
  import rns_pkg::*;

  localparam int WATCHDOG_LIMIT  = 20000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PRINT_CAP       = 50;
  localparam logic [RAD_W-1:0] RAD_MAX = {RAD_W{1'b1}};

  typedef struct packed {
    logic                 accepted;
    logic                 dropped_full;
    logic [OUT_IDX_W-1:0] new_index;
    logic [OUT_CNT_W-1:0] stored_count;
  } node_result_t;

  typedef enum {ROW_WORD, ROW_RADIUS} row_kind_t;
  typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PATTERN} ready_mode_t;

  typedef struct {
    row_kind_t        kind;
    logic             op;
    int               x;
    int               y;
    int               z;
    logic [RAD_W-1:0] radius;
    bit               typed;
    node_result_t     want;
  } stim_row_t;

  typedef struct {
    int x;
    int y;
    int z;
  } point_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [RAD_W-1:0]  cfg_wdata;
  logic              in_tvalid;
  logic              in_tready;
  logic [63:0]       in_tdata;    // point_x, point_y, point_z, zero pad
  logic              in_tuser;    // opcode
  logic              out_tvalid;
  logic              out_tready;
  logic [31:0]       out_tdata;   // new_index, stored_count, zero pad
  logic [1:0]        out_tuser;   // accepted, dropped_full

  // A word can carry a hand-written expectation alongside its data.
  bit                word_typed;
  node_result_t      word_want;

  // Shadow copy of the node table and the radius register.
  logic signed [COORD_W-1:0] table_x [MAX_NODES];
  logic signed [COORD_W-1:0] table_y [MAX_NODES];
  logic signed [COORD_W-1:0] table_z [MAX_NODES];
  int                        table_count  = 0;
  logic [RAD_W-1:0]          radius_sq    = RAD_RESET;

  node_result_t pending_results [$];
  int           error_count  = 0;
  int           stall_cycles = 0;
  int           burst_left   = 4;
  bit           steady_sender = 0;
  bit           hold_off_req  = 0;

  radius_node_subsampler_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Greedy subsampling of one word against the shadow table.
  function automatic node_result_t subsample_word(input logic op,
                                                  input logic signed [COORD_W-1:0] px,
                                                  input logic signed [COORD_W-1:0] py,
                                                  input logic signed [COORD_W-1:0] pz);
    node_result_t      res;
    bit                isolated;
    longint            dx;
    longint            dy;
    longint            dz;
    longint unsigned   dist_sum;
    res = '0;
    if (op == OP_CLEAR) begin
      table_count = 0;
    end else begin
      isolated = 1'b1;
      for (int i = 0; i < table_count && isolated; i++) begin
        dx = longint'(px) - longint'(table_x[i]);
        dy = longint'(py) - longint'(table_y[i]);
        dz = longint'(pz) - longint'(table_z[i]);
        dist_sum = longint'(dx * dx + dy * dy + dz * dz);
        if (dist_sum < {20'd0, radius_sq}) begin
          isolated = 1'b0;
        end
      end
      if (isolated) begin
        if (table_count >= MAX_NODES) begin
          res.dropped_full = 1'b1;
        end else begin
          table_x[table_count] = px;
          table_y[table_count] = py;
          table_z[table_count] = pz;
          res.accepted  = 1'b1;
          res.new_index = table_count[OUT_IDX_W-1:0];
          table_count++;
        end
      end
    end
    res.stored_count = table_count[OUT_CNT_W-1:0];
    return res;
  endfunction

  function automatic logic signed [COORD_W-1:0] to_coord(input int v);
    return v[COORD_W-1:0];
  endfunction

  // Keeps a perturbed coordinate inside the signed 20-bit range.
  function automatic int clamp_coord(input int v);
    if (v > 524287) begin
      return 524287;
    end
    if (v < -524288) begin
      return -524288;
    end
    return v;
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 1048575)) - 524288;
  endfunction

  function automatic stim_row_t word_row(input logic op, input int x, input int y, input int z);
    stim_row_t r;
    r = '{kind: ROW_WORD, op: op, x: x, y: y, z: z, radius: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic stim_row_t checked_row(input logic op, input int x, input int y,
                                            input int z, input logic acc, input logic drop,
                                            input int idx, input int cnt);
    stim_row_t r;
    r = word_row(op, x, y, z);
    r.typed = 1'b1;
    r.want.accepted     = acc;
    r.want.dropped_full = drop;
    r.want.new_index    = idx[OUT_IDX_W-1:0];
    r.want.stored_count = cnt[OUT_CNT_W-1:0];
    return r;
  endfunction

  function automatic stim_row_t radius_row(input logic [RAD_W-1:0] v);
    stim_row_t r;
    r = word_row(OP_CLEAR, 0, 0, 0);
    r.kind   = ROW_RADIUS;
    r.radius = v;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    error_count++;
    if (error_count <= PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s got %0d expected %0d", $time, field, got, want);
    end
  endtask

  // Offers one word, waits for the handshake, then paces the next burst.
  task automatic send_word(input logic op, input int x, input int y, input int z,
                           input bit typed, input node_result_t want);
    in_tvalid  <= 1'b1;
    in_tuser   <= op;
    in_tdata   <= {4'b0, to_coord(z), to_coord(y), to_coord(x)};
    word_typed <= typed;
    word_want  <= want;
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    if (!steady_sender) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  task automatic send_point(input int x, input int y, input int z);
    send_word(OP_POINT, x, y, z, 1'b0, '0);
  endtask

  // The radius is only written once every word has produced its result.
  task automatic write_radius(input logic [RAD_W-1:0] v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    radius_sq = v;
  endtask

  // Result checking first, then the prediction for a newly taken word.
  always @(posedge clk) begin : result_check
    node_result_t want;
    node_result_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected result word, stored_count", out_tdata[24:12], -1);
        end else begin
          want = pending_results.pop_front();
          if (out_tuser[0] !== want.accepted) begin
            report_mismatch("accepted", out_tuser[0], want.accepted);
          end
          if (out_tuser[1] !== want.dropped_full) begin
            report_mismatch("dropped_full", out_tuser[1], want.dropped_full);
          end
          if (out_tdata[11:0] !== want.new_index) begin
            report_mismatch("new_index", out_tdata[11:0], want.new_index);
          end
          if (out_tdata[24:12] !== want.stored_count) begin
            report_mismatch("stored_count", out_tdata[24:12], want.stored_count);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        got = subsample_word(in_tuser, in_tdata[19:0], in_tdata[39:20], in_tdata[59:40]);
        pending_results = {pending_results, (word_typed ? word_want : got)};
      end
    end
  end

  // Ends the run when neither side has moved a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: stretches of steady, random and patterned readiness, plus one long hold-off.
  initial begin : receiver
    ready_mode_t mode;
    int          span;
    int          tick;
    tick = 0;
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end
      mode = ready_mode_t'($urandom_range(0, 2));
      span = $urandom_range(8, 120);
      repeat (span) begin
        tick++;
        case (mode)
          RDY_ALWAYS: out_tready <= 1'b1;
          RDY_RANDOM: out_tready <= ($urandom_range(0, 2) != 0);
          default:    out_tready <= ((tick % 7) < 4);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    stim_row_t directed_plan [$];
    point_t    recent [$];
    point_t    pt;
    point_t    base;
    longint    rad;
    int        spread;
    int        words;
    int        pick;

    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= OP_CLEAR;
    word_typed <= 1'b0;
    word_want  <= '0;

    // Directed part: extremes, the radius boundary, clears and full-range radii.
    directed_plan = {directed_plan, checked_row(OP_POINT, 0, 0, 0, 1, 0, 0, 1)};
    directed_plan = {directed_plan, checked_row(OP_POINT, 0, 0, 0, 0, 0, 0, 1)};
    directed_plan = {directed_plan, checked_row(OP_POINT, 524287, 524287, 524287, 1, 0, 1, 2)};
    directed_plan = {directed_plan, checked_row(OP_POINT, -524288, -524288, -524288, 1, 0, 2, 3)};
    directed_plan = {directed_plan, checked_row(OP_POINT, -524288, 524287, 0, 1, 0, 3, 4)};
    directed_plan = {directed_plan, word_row(OP_POINT, 1638, 0, 0)};
    directed_plan = {directed_plan, word_row(OP_POINT, 1639, 0, 0)};
    directed_plan = {directed_plan, word_row(OP_POINT, 0, -1638, 1)};
    directed_plan = {directed_plan, checked_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0)};
    directed_plan = {directed_plan, checked_row(OP_CLEAR, -1, -1, -1, 0, 0, 0, 0)};
    directed_plan = {directed_plan, radius_row(RAD_W'(100))};
    directed_plan = {directed_plan, checked_row(OP_POINT, 0, 0, 0, 1, 0, 0, 1)};
    // A distance equal to the radius does not reject.
    directed_plan = {directed_plan, checked_row(OP_POINT, 10, 0, 0, 1, 0, 1, 2)};
    directed_plan = {directed_plan, word_row(OP_POINT, 9, 4, 1)};
    directed_plan = {directed_plan, word_row(OP_POINT, -6, -8, 0)};
    directed_plan = {directed_plan, radius_row('0)};
    directed_plan = {directed_plan, word_row(OP_POINT, 10, 0, 0)};
    directed_plan = {directed_plan, radius_row(RAD_MAX)};
    directed_plan = {directed_plan, word_row(OP_POINT, 524287, -524288, 524287)};
    directed_plan = {directed_plan, checked_row(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0)};
    directed_plan = {directed_plan, checked_row(OP_POINT, -524288, -524288, -524288, 1, 0, 0, 1)};
    directed_plan = {directed_plan, word_row(OP_CLEAR, 0, 0, 0)};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_RADIUS) begin
        write_radius(directed_plan[i].radius);
      end else begin
        send_word(directed_plan[i].op, directed_plan[i].x, directed_plan[i].y,
                  directed_plan[i].z, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Random sets: each picks a radius, clears the table and offers points,
    // most of them close to earlier points so that both outcomes occur.
    for (int set_i = 0; set_i < 6; set_i++) begin
      case ($urandom_range(0, 5))
        0: begin
          rad    = RAD_RESET;
          spread = 1640;
        end
        1: begin
          rad    = 0;
          spread = 64;
        end
        2: begin
          rad    = {$urandom, $urandom};
          spread = 4096;
        end
        default: begin
          spread = $urandom_range(1, 3000);
          rad    = longint'(spread) * spread * $urandom_range(1, 3);
        end
      endcase
      write_radius(rad[RAD_W-1:0]);
      // The first set runs without gaps against a long receiver hold-off.
      steady_sender = (set_i == 0);
      hold_off_req  = (set_i == 0);
      recent.delete();
      send_word(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
      words = $urandom_range(12, 24);
      repeat (words) begin
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_word(OP_CLEAR, rand_coord(), rand_coord(), rand_coord(), 1'b0, '0);
          recent.delete();
        end else begin
          if (pick < 65 && recent.size() != 0) begin
            base = recent[$urandom_range(0, recent.size() - 1)];
            pt.x = clamp_coord(base.x + int'($urandom_range(0, 2 * spread)) - spread);
            pt.y = clamp_coord(base.y + int'($urandom_range(0, 2 * spread)) - spread);
            pt.z = clamp_coord(base.z + int'($urandom_range(0, 2 * spread)) - spread);
          end else if (pick < 85) begin
            pt.x = rand_coord();
            pt.y = rand_coord();
            pt.z = rand_coord();
          end else begin
            pt.x = int'($urandom_range(0, 8 * spread)) - 4 * spread;
            pt.y = int'($urandom_range(0, 8 * spread)) - 4 * spread;
            pt.z = int'($urandom_range(0, 8 * spread)) - 4 * spread;
          end
          send_point(pt.x, pt.y, pt.z);
          recent = {recent, pt};
        end
      end
    end
    steady_sender = 1'b0;

    // The largest radius and then a zero radius on the table left by the last set.
    write_radius(RAD_MAX);
    send_point(rand_coord(), rand_coord(), rand_coord());
    write_radius('0);
    send_point(524287, 524287, 524287);
    send_word(OP_CLEAR, 0, 0, 0, 1'b0, '0);
    send_point(rand_coord(), rand_coord(), rand_coord());

    // Drain every outstanding result, then allow a short settling time.
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- radius_node_subsampler_top.f -----
+incdir+rtl/core
rtl/core/rns_pkg.sv
rtl/core/rns_ctrl.sv
rtl/core/rns_dpath.sv
rtl/core/radius_node_subsampler_top.sv
dv/radius_node_subsampler_top_test.sv
